@@ hw/rtl/trs_pkg.sv @@
`default_nettype none

package trs_pkg;

  localparam int TRS_TENSOR_DEPTH = 4096;
  localparam int TRS_BATCH_DEPTH  = 256;

  localparam int TRS_KIND_W   = 2;
  localparam int TRS_POS_W    = 12;
  localparam int TRS_VAL_W    = 64;
  localparam int TRS_STRIDE_W = 13;
  localparam int TRS_BSIZE_W  = 9;
  localparam int TRS_LEN_W    = 13;
  localparam int TRS_STATUS_W = 2;
  localparam int TRS_CFG_W    = 2;

  localparam logic [TRS_KIND_W-1:0] KIND_LEN  = 2'd0;
  localparam logic [TRS_KIND_W-1:0] KIND_ELEM = 2'd1;
  localparam logic [TRS_KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [TRS_STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [TRS_STATUS_W-1:0] ST_BAD_LEN = 2'd1;
  localparam logic [TRS_STATUS_W-1:0] ST_BAD_POS = 2'd2;

  localparam logic [TRS_CFG_W-1:0] CFG_INNER_STRIDE = 2'd0;
  localparam logic [TRS_CFG_W-1:0] CFG_SEQ_SIZE     = 2'd1;
  localparam logic [TRS_CFG_W-1:0] CFG_BATCH_STRIDE = 2'd2;
  localparam logic [TRS_CFG_W-1:0] CFG_BATCH_SIZE   = 2'd3;

  typedef struct packed {
    logic                    start;
    logic [TRS_POS_W-1:0]    dividend;
    logic [TRS_STRIDE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [TRS_POS_W-1:0]    quot;
    logic [TRS_STRIDE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/trs_div.sv @@
`default_nettype none

module trs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trs_pkg::div_req_t req,
  output trs_pkg::div_rsp_t      rsp
);
  import trs_pkg::*;

  localparam int CNT_W = $clog2(TRS_POS_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TRS_POS_W - 1);

  logic                    busy;
  logic                    done;
  logic [CNT_W-1:0]        cnt;
  logic [TRS_POS_W-1:0]    quot;
  logic [TRS_STRIDE_W-1:0] rem;
  logic [TRS_STRIDE_W-1:0] divisor;
  logic [TRS_STRIDE_W:0]   trial;
  logic [TRS_STRIDE_W:0]   diff;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[TRS_POS_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      quot    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quot <= {quot[TRS_POS_W-2:0], fits};
      rem  <= fits ? diff[TRS_STRIDE_W-1:0] : trial[TRS_STRIDE_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

@@ hw/rtl/tensor_reverse_sequence.sv @@
// Reverse-sequence tensor store.
// Input channel (in_valid / in_stall) carries kind, position and value; a beat
// is taken when in_valid is high and in_stall is low. kind 0 writes a sequence
// length, kind 1 writes a tensor element, kind 2 reads an output element with
// the first length entries of its sequence reversed. Every input beat gives
// exactly one output beat (element, status) on out_valid / out_stall.
// Writes and unknown kinds go from acceptance straight to the result state. A
// read runs four 12-bit divisions one after another on one shared bit-serial
// divider to find the sequence and batch index, then a length table read, two
// multiplies, the source address and a tensor store read. A read that fails its
// batch index check skips the remaining steps and goes to the result state. One
// beat is in flight at a time; in_stall is high from acceptance until the result
// is moved to the output register, so no new beat is taken before it is done.
// The output register lets the next beat be taken while a result waits; while
// out_stall is high the result holds, and a new result waits inside the block.
// Reset sets all four config registers to 1 and empties the pipeline; the
// length table and tensor store are not cleared and must be written before
// they are read. Config is written through cfg_write / cfg_index / cfg_data.
`default_nettype none

module tensor_reverse_sequence #(
  parameter int TENSOR_DEPTH = trs_pkg::TRS_TENSOR_DEPTH,
  parameter int BATCH_DEPTH  = trs_pkg::TRS_BATCH_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [trs_pkg::TRS_CFG_W-1:0]         cfg_index,
  input  wire logic [trs_pkg::TRS_STRIDE_W-1:0]      cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [trs_pkg::TRS_KIND_W-1:0]        kind,
  input  wire logic [trs_pkg::TRS_POS_W-1:0]         position,
  input  wire logic signed [trs_pkg::TRS_VAL_W-1:0]  value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [trs_pkg::TRS_VAL_W-1:0]       element,
  output logic [trs_pkg::TRS_STATUS_W-1:0]           status
);
  import trs_pkg::*;

  localparam int TAW = (TENSOR_DEPTH > 1) ? $clog2(TENSOR_DEPTH) : 1;
  localparam int BAW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int PROD_W = 2 * TRS_STRIDE_W;
  localparam int SRC_W = PROD_W + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_SRC  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_TRD  = 4'd7;
  localparam logic [3:0] S_RES  = 4'd8;

  // config registers and their zero-as-one views
  logic [TRS_STRIDE_W-1:0] inner_stride;
  logic [TRS_STRIDE_W-1:0] seq_axis_size;
  logic [TRS_STRIDE_W-1:0] batch_stride;
  logic [TRS_BSIZE_W-1:0]  batch_axis_size;
  logic [TRS_STRIDE_W-1:0] inner_eff;
  logic [TRS_STRIDE_W-1:0] seq_eff;
  logic [TRS_STRIDE_W-1:0] bstr_eff;
  logic [TRS_BSIZE_W-1:0]  bsize_eff;

  logic [3:0]              state;
  logic [1:0]              step;
  logic [TRS_POS_W-1:0]    pos_q;
  logic [TRS_STRIDE_W-1:0] seq_idx;
  logic [TRS_LEN_W-1:0]    len;
  logic                    flip;
  logic [PROD_W-1:0]       prod;
  logic [TRS_POS_W-1:0]    base;
  logic [SRC_W-1:0]        src;
  logic signed [TRS_VAL_W-1:0] res_elem;
  logic [TRS_STATUS_W-1:0] res_status;

  logic                    accept;
  logic [31:0]             pos_wide;
  logic                    pos_ok;
  logic                    bpos_ok;
  logic                    len_bad;
  logic [31:0]             b_wide;
  logic                    b_ok;
  logic [31:0]             src_wide;
  logic                    src_ok;
  logic                    out_load;

  logic [TRS_STRIDE_W-1:0] mul_a;
  logic [TRS_STRIDE_W-1:0] len_m1;
  logic [PROD_W-1:0]       mul_p;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    l_we;
  logic                    l_re;
  logic [BAW-1:0]          l_waddr;
  logic [BAW-1:0]          l_raddr;
  logic [TRS_LEN_W-1:0]    l_rd;
  logic                    t_we;
  logic                    t_re;
  logic [TAW-1:0]          t_waddr;
  logic [TAW-1:0]          t_raddr;
  logic [TRS_VAL_W-1:0]    t_rd;

  logic [TRS_LEN_W-1:0]    len_mem [BATCH_DEPTH];
  logic [TRS_VAL_W-1:0]    tensor_mem [TENSOR_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_stride    <= TRS_STRIDE_W'(1);
      seq_axis_size   <= TRS_STRIDE_W'(1);
      batch_stride    <= TRS_STRIDE_W'(1);
      batch_axis_size <= TRS_BSIZE_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INNER_STRIDE: inner_stride    <= cfg_data;
        CFG_SEQ_SIZE:     seq_axis_size   <= cfg_data;
        CFG_BATCH_STRIDE: batch_stride    <= cfg_data;
        CFG_BATCH_SIZE:   batch_axis_size <= cfg_data[TRS_BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign inner_eff = (inner_stride == '0) ? TRS_STRIDE_W'(1) : inner_stride;
  assign seq_eff   = (seq_axis_size == '0) ? TRS_STRIDE_W'(1) : seq_axis_size;
  assign bstr_eff  = (batch_stride == '0) ? TRS_STRIDE_W'(1) : batch_stride;
  assign bsize_eff = (batch_axis_size == '0) ? TRS_BSIZE_W'(1) : batch_axis_size;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;

  assign pos_wide = 32'(position);
  assign pos_ok   = pos_wide < 32'(TENSOR_DEPTH);
  assign bpos_ok  = pos_wide < 32'(BATCH_DEPTH);
  assign len_bad  = value[TRS_VAL_W-1] || (|value[TRS_VAL_W-2:TRS_LEN_W])
                    || (value[TRS_LEN_W-1:0] > seq_eff);

  assign b_wide   = 32'(div_rsp.rem);
  assign b_ok     = b_wide < 32'(BATCH_DEPTH);
  assign src_wide = 32'(src);
  assign src_ok   = src_wide < 32'(TENSOR_DEPTH);

  // index chain: p / inner, then % size, p / bstride, then % bsize
  always_comb begin
    div_req = '0;
    if (accept && kind == KIND_READ && pos_ok) begin
      div_req.start    = 1'b1;
      div_req.dividend = position;
      div_req.divisor  = inner_eff;
    end else if (state == S_DIV && div_rsp.done) begin
      case (step)
        2'd0: begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot;
          div_req.divisor  = seq_eff;
        end
        2'd1: begin
          div_req.start    = 1'b1;
          div_req.dividend = pos_q;
          div_req.divisor  = bstr_eff;
        end
        2'd2: begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot;
          div_req.divisor  = TRS_STRIDE_W'(bsize_eff);
        end
        default: ;
      endcase
    end
  end

  trs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // length table
  assign l_we    = accept && kind == KIND_LEN && bpos_ok && !len_bad;
  assign l_waddr = pos_wide[BAW-1:0];
  assign l_re    = state == S_DIV && div_rsp.done && step == 2'd3 && b_ok;
  assign l_raddr = b_wide[BAW-1:0];

  always_ff @(posedge clk) begin
    if (l_we) begin
      len_mem[l_waddr] <= value[TRS_LEN_W-1:0];
    end
    if (l_re) begin
      l_rd <= len_mem[l_raddr];
    end
  end

  // tensor store
  assign t_we    = accept && kind == KIND_ELEM && pos_ok;
  assign t_waddr = pos_wide[TAW-1:0];
  assign t_re    = state == S_CHK && src_ok;
  assign t_raddr = src_wide[TAW-1:0];

  always_ff @(posedge clk) begin
    if (t_we) begin
      tensor_mem[t_waddr] <= value;
    end
    if (t_re) begin
      t_rd <= tensor_mem[t_raddr];
    end
  end

  // shared multiplier: i * inner, then (len - 1 - i) * inner
  assign len_m1 = len - TRS_STRIDE_W'(1) - seq_idx;
  assign mul_a  = (state == S_MUL1) ? seq_idx : len_m1;
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(inner_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (kind == KIND_READ && pos_ok) begin
              state <= S_DIV;
              step  <= 2'd0;
            end else begin
              state <= S_RES;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            step <= step + 2'd1;
            if (step == 2'd3) begin
              state <= b_ok ? S_LEN : S_RES;
            end
          end
        end
        S_LEN:  state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_SRC;
        S_SRC:  state <= S_CHK;
        S_CHK:  state <= src_ok ? S_TRD : S_RES;
        S_TRD:  state <= S_RES;
        S_RES: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pos_q      <= position;
        res_elem   <= '0;
        res_status <= ST_OK;
        case (kind)
          KIND_LEN: begin
            if (!bpos_ok) begin
              res_status <= ST_BAD_POS;
            end else if (len_bad) begin
              res_status <= ST_BAD_LEN;
            end
          end
          KIND_ELEM, KIND_READ: begin
            if (!pos_ok) begin
              res_status <= ST_BAD_POS;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done && step == 2'd1) begin
          seq_idx <= div_rsp.rem;
        end
        if (div_rsp.done && step == 2'd3 && !b_ok) begin
          res_status <= ST_BAD_POS;
        end
      end
      S_LEN: begin
        // a length stored under a larger axis size saturates
        len <= (l_rd > seq_eff) ? seq_eff : l_rd;
      end
      S_MUL1: begin
        prod <= mul_p;
        flip <= seq_idx < len;
      end
      S_MUL2: begin
        base <= pos_q - prod[TRS_POS_W-1:0];
        prod <= mul_p;
      end
      S_SRC: begin
        src <= flip ? (SRC_W'(base) + SRC_W'(prod)) : SRC_W'(pos_q);
      end
      S_CHK: begin
        if (!src_ok) begin
          res_status <= ST_BAD_POS;
        end
      end
      S_TRD: begin
        res_elem   <= $signed(t_rd);
        res_status <= ST_OK;
      end
      default: ;
    endcase
  end

  // output register
  assign out_load = state == S_RES && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      element <= res_elem;
      status  <= res_status;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken while a beat is in flight");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the index phase");

  a_len_read: assert property (@(posedge clk) disable iff (rst)
    l_re |=> state == S_LEN)
    else $error("length read not followed by length phase");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RES)
    else $error("output loaded outside result state");

endmodule

`default_nettype wire

@@ bench/tb_tensor_reverse_sequence.sv @@
`timescale 1ns / 100ps

module tb_tensor_reverse_sequence;
  import trs_pkg::*;

  localparam logic [TRS_KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int BIW = $clog2(TRS_BATCH_DEPTH);
  localparam int TIW = $clog2(TRS_TENSOR_DEPTH);

  typedef struct packed {
    logic [TRS_VAL_W-1:0]    element;
    logic [TRS_STATUS_W-1:0] status;
  } answer_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [TRS_CFG_W-1:0]           cfg_index = '0;
  logic [TRS_STRIDE_W-1:0]        cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [TRS_KIND_W-1:0]          kind = '0;
  logic [TRS_POS_W-1:0]           position = '0;
  logic signed [TRS_VAL_W-1:0]    value = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [TRS_VAL_W-1:0]    element;
  logic [TRS_STATUS_W-1:0]        status;

  // shadow copy of the block's registers and stores
  logic [TRS_STRIDE_W-1:0] cfg_inner = 13'd1;
  logic [TRS_STRIDE_W-1:0] cfg_seq   = 13'd1;
  logic [TRS_STRIDE_W-1:0] cfg_bstr  = 13'd1;
  logic [TRS_BSIZE_W-1:0]  cfg_bsize = 9'd1;
  logic [TRS_LEN_W-1:0]    len_table [TRS_BATCH_DEPTH];
  bit                      len_written [TRS_BATCH_DEPTH];
  logic [TRS_VAL_W-1:0]    store_mem [TRS_TENSOR_DEPTH];
  bit                      elem_written [TRS_TENSOR_DEPTH];

  answer_t     awaited_answers [$];
  int          errors = 0;
  int unsigned beats_sent = 0;
  int unsigned shape_span = TRS_TENSOR_DEPTH;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          offering = 1'b0;
  logic        holding = 1'b0;
  longint      cycles = 0;
  event        start_hold;

  tensor_reverse_sequence u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .element   (element),
    .status    (status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned nonzero(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [TRS_VAL_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // batch index and source position of an output position; src past the store
  // when the batch index is out of the length table
  function automatic void locate_source(input logic [TRS_POS_W-1:0] p,
                                        output int unsigned b,
                                        output longint unsigned src);
    int unsigned inner, size, i, len;
    inner = nonzero(cfg_inner);
    size  = nonzero(cfg_seq);
    i     = (32'(p) / inner) % size;
    b     = (32'(p) / nonzero(cfg_bstr)) % nonzero(cfg_bsize);
    src   = 64'(TRS_TENSOR_DEPTH);
    if (b < TRS_BATCH_DEPTH) begin
      len = 32'(len_table[BIW'(b)]);
      // stale length saturates to the current axis size
      if (len > size) len = size;
      src = 64'(p);
      if (i < len) src = 64'(32'(p) - i * inner + (len - 1 - i) * inner);
    end
  endfunction

  function automatic answer_t predict_beat(input logic [TRS_KIND_W-1:0] k,
                                           input logic [TRS_POS_W-1:0] p,
                                           input logic [TRS_VAL_W-1:0] v);
    answer_t a;
    int unsigned b;
    longint unsigned src;
    a.element = '0;
    a.status  = ST_OK;
    case (k)
      KIND_LEN: begin
        if (p >= TRS_BATCH_DEPTH) a.status = ST_BAD_POS;
        else if (v[TRS_VAL_W-1] || v > nonzero(cfg_seq)) a.status = ST_BAD_LEN;
        else begin
          len_table[p[BIW-1:0]]   = v[TRS_LEN_W-1:0];
          len_written[p[BIW-1:0]] = 1'b1;
        end
      end
      KIND_ELEM: begin
        store_mem[p]    = v;
        elem_written[p] = 1'b1;
      end
      KIND_READ: begin
        locate_source(p, b, src);
        if (src >= TRS_TENSOR_DEPTH) a.status = ST_BAD_POS;
        else a.element = store_mem[TIW'(src)];
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_beat(input logic [TRS_KIND_W-1:0] k, input logic [TRS_POS_W-1:0] p,
                           input logic [TRS_VAL_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    offering = 1'b1;
    kind     <= k;
    position <= p;
    value    <= v;
    do @(posedge clk); while (in_stall);
    awaited_answers.insert(awaited_answers.size(), predict_beat(k, p, v));
    beats_sent++;
  endtask

  task automatic wait_for_answers();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(input int unsigned inner_v, input int unsigned seq_v,
                             input int unsigned bstr_v, input int unsigned bsize_v);
    logic [TRS_CFG_W-1:0]    which [4];
    logic [TRS_STRIDE_W-1:0] data [4];
    which = '{CFG_INNER_STRIDE, CFG_SEQ_SIZE, CFG_BATCH_STRIDE, CFG_BATCH_SIZE};
    data  = '{13'(inner_v), 13'(seq_v), 13'(bstr_v), 13'(bsize_v)};
    wait_for_answers();
    for (int n = 0; n < 4; n++) begin
      cfg_write <= 1'b1;
      cfg_index <= which[n];
      cfg_data  <= data[n];
      @(posedge clk);
      case (which[n])
        CFG_INNER_STRIDE: cfg_inner = data[n];
        CFG_SEQ_SIZE:     cfg_seq   = data[n];
        CFG_BATCH_STRIDE: cfg_bstr  = data[n];
        default:          cfg_bsize = data[n][TRS_BSIZE_W-1:0];
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // a read never touches an unwritten entry: fill the length and source first
  task automatic read_after_fill(input logic [TRS_POS_W-1:0] p);
    int unsigned b;
    longint unsigned src;
    locate_source(p, b, src);
    if (b < TRS_BATCH_DEPTH && !len_written[BIW'(b)]) begin
      send_beat(KIND_LEN, 12'(b), 64'($urandom_range(0, nonzero(cfg_seq))));
      locate_source(p, b, src);
    end
    if (src < TRS_TENSOR_DEPTH && !elem_written[TIW'(src)])
      send_beat(KIND_ELEM, 12'(src), rand64());
    send_beat(KIND_READ, p, rand64());
  endtask

  task automatic random_beat();
    int unsigned r, batches;
    logic [TRS_VAL_W-1:0] v;
    r = $urandom_range(99);
    batches = (nonzero(cfg_bsize) > TRS_BATCH_DEPTH) ? TRS_BATCH_DEPTH : nonzero(cfg_bsize);
    if (r < 15)
      send_beat(KIND_LEN, 12'($urandom_range(0, batches - 1)),
                64'($urandom_range(0, nonzero(cfg_seq))));
    else if (r < 40)
      send_beat(KIND_ELEM, 12'($urandom_range(0, shape_span - 1)), rand64());
    else if (r < 88)
      read_after_fill(12'($urandom_range(0, shape_span - 1)));
    else case ($urandom_range(4))
      0: send_beat(KIND_NONE, 12'($urandom()), rand64());
      1: send_beat(KIND_LEN, 12'($urandom_range(TRS_BATCH_DEPTH, TRS_TENSOR_DEPTH - 1)),
                   64'($urandom_range(0, nonzero(cfg_seq))));
      2: begin
        v = rand64();
        if (v[0]) v[TRS_VAL_W-1] = 1'b1;
        else v = 64'(nonzero(cfg_seq) + $urandom_range(1, 100));
        send_beat(KIND_LEN, 12'($urandom_range(0, batches - 1)), v);
      end
      3: read_after_fill(12'($urandom()));
      default: send_beat(KIND_ELEM, 12'($urandom()), rand64());
    endcase
  endtask

  task automatic pick_shape();
    int unsigned nb, ns, ni;
    nb = $urandom_range(1, 8);
    ns = $urandom_range(1, 16);
    ni = $urandom_range(1, 8);
    case ($urandom_range(3))
      0: begin
        // batch axis ahead of the sequence axis
        reconfigure(ni, ns, ns * ni, nb);
        shape_span = nb * ns * ni;
      end
      1: begin
        // sequence axis ahead of the batch axis
        reconfigure(nb * ni, ns, ni, nb);
        shape_span = nb * ns * ni;
      end
      2: begin
        ns = $urandom_range(1, 64);
        reconfigure(1, ns, ns, nb);
        shape_span = nb * ns;
      end
      default: begin
        reconfigure($urandom_range(0, 8191), $urandom_range(0, 200),
                    $urandom_range(0, 8191), $urandom_range(0, 8191));
        shape_span = TRS_TENSOR_DEPTH;
      end
    endcase
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_beat(KIND_NONE, 12'hfff, '1);
    send_beat(KIND_NONE, 12'h000, '0);
    send_beat(KIND_LEN, 12'd0, 64'd1);
    send_beat(KIND_LEN, 12'd255, 64'd0);
    send_beat(KIND_LEN, 12'd256, 64'd0);
    send_beat(KIND_LEN, 12'hfff, 64'd1);
    send_beat(KIND_LEN, 12'd1, '1);
    send_beat(KIND_LEN, 12'd1, 64'd2);
    send_beat(KIND_LEN, 12'd1, 64'h8000_0000_0000_0000);
    send_beat(KIND_ELEM, 12'd0, 64'h7fff_ffff_ffff_ffff);
    send_beat(KIND_ELEM, 12'hfff, 64'h8000_0000_0000_0000);
    read_after_fill(12'd0);
    read_after_fill(12'hfff);
    // zero registers behave as one
    reconfigure(0, 0, 0, 0);
    read_after_fill(12'hfff);
    // shape 2 x 4 x 2, batch ahead of sequence
    reconfigure(2, 4, 8, 2);
    send_beat(KIND_LEN, 12'd0, 64'd4);
    send_beat(KIND_LEN, 12'd1, 64'd2);
    read_after_fill(12'd0);
    read_after_fill(12'd9);
    read_after_fill(12'd13);
    // shrink the axis: stored length of 4 saturates to 2
    reconfigure(2, 2, 8, 2);
    read_after_fill(12'd0);
    // reversed source lands past the store at position 100, inside it at 1100
    reconfigure(1000, 5, 1, 1);
    send_beat(KIND_LEN, 12'd0, 64'd5);
    read_after_fill(12'd100);
    read_after_fill(12'd1100);
    // batch size masked to 511, batch index past the table at 300, inside it at 4095
    reconfigure(1, 1, 1, 8191);
    read_after_fill(12'd300);
    read_after_fill(12'hfff);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned mark;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int blk = 0; blk < n / 50; blk++) begin
      pick_shape();
      mark = beats_sent;
      while (beats_sent - mark < 50) random_beat();
    end
  endtask

  task automatic test_extreme_shapes();
    int unsigned shapes [6][4];
    int unsigned mark;
    shapes = '{'{4096, 4096, 4096, 256}, '{8191, 8191, 8191, 8191}, '{1, 1, 1, 1},
               '{0, 0, 0, 0}, '{1, 4096, 4096, 1}, '{1, 8191, 1, 256}};
    send_idle_pct = 30;
    stall_pct = 30;
    for (int s = 0; s < 6; s++) begin
      reconfigure(shapes[s][0], shapes[s][1], shapes[s][2], shapes[s][3]);
      shape_span = TRS_TENSOR_DEPTH;
      mark = beats_sent;
      while (beats_sent - mark < 30) random_beat();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    pick_shape();
    // receiver holds off while beats keep coming, block fills and stalls
    -> start_hold;
    repeat (30) random_beat();
    wait_for_answers();
    repeat (30) random_beat();
  endtask

  initial begin
    forever begin
      @(start_hold);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got element %h status %0d",
                 $time, element, status);
      end else begin
        want = awaited_answers.pop_front();
        if (element !== want.element) begin
          errors++;
          $display("%0t: element mismatch, expected %h, got %h", $time, want.element, element);
        end
        if (status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 68, 0);
    test_random_traffic(200, 0, 68);
    test_random_traffic(200, 30, 30);
    test_extreme_shapes();
    test_backpressure();
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ tensor_reverse_sequence.f @@
hw/rtl/trs_pkg.sv
hw/rtl/trs_div.sv
hw/rtl/tensor_reverse_sequence.sv
bench/tb_tensor_reverse_sequence.sv
